[rtl/m3inv_pkg.sv]
// Package for the 3x3 matrix inverse: widths, payload types and helper constants.
package m3inv_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int DW             = DATA_WIDTH_DEF;

	typedef struct packed {
		logic signed [DW-1:0] m11;
		logic signed [DW-1:0] m12;
		logic signed [DW-1:0] m13;
		logic signed [DW-1:0] m21;
		logic signed [DW-1:0] m22;
		logic signed [DW-1:0] m23;
		logic signed [DW-1:0] m31;
		logic signed [DW-1:0] m32;
		logic signed [DW-1:0] m33;
	} mat_in_t;

	typedef struct packed {
		logic signed [DW-1:0] inv11;
		logic signed [DW-1:0] inv12;
		logic signed [DW-1:0] inv13;
		logic signed [DW-1:0] inv21;
		logic signed [DW-1:0] inv22;
		logic signed [DW-1:0] inv23;
		logic signed [DW-1:0] inv31;
		logic signed [DW-1:0] inv32;
		logic signed [DW-1:0] inv33;
		logic                 singular;
		logic                 overflow;
	} mat_out_t;

endpackage

[rtl/m3inv_div.sv]
// Pipelined restoring divider: one quotient bit per stage, with saturation.
module m3inv_div import m3inv_pkg::*; #(
	parameter int NW = 64,
	parameter int DWD = 97,
	parameter int QW = 33,
	parameter int OW = 32
) (
	input  logic              clk,
	input  logic              en,
	input  logic [NW-1:0]     num,
	input  logic [DWD-1:0]    den,
	input  logic              neg,
	output logic [OW-1:0]     quo,
	output logic              sat
);
	// Quotient bits above QW are settled by a magnitude test before stage 0:
	// if num >= den << QW the result saturates anyway.
	logic [NW-1:0]  rem_s  [QW+1];
	logic [DWD-1:0] den_s  [QW+1];
	logic [QW-1:0]  q_s    [QW+1];
	logic           neg_s  [QW+1];
	logic           big_s  [QW+1];

	always_comb begin
		rem_s[0] = num;
		den_s[0] = den;
		q_s[0]   = '0;
		neg_s[0] = neg;
		big_s[0] = ({{(DWD+QW){1'b0}}, num} >= ({{(NW+QW){1'b0}}, den} << QW));
	end

	for (genvar k = 0; k < QW; k++) begin : g_st
		localparam int SH = QW - 1 - k;
		logic [NW+DWD+QW-1:0] dsh;
		logic                 ge;
		logic [NW+DWD+QW-1:0] rwide;
		assign dsh   = {{(NW+QW){1'b0}}, den_s[k]} << SH;
		assign rwide = {{(DWD+QW){1'b0}}, rem_s[k]};
		assign ge    = rwide >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? NW'(rwide - dsh) : rem_s[k];
				den_s[k+1] <= den_s[k];
				q_s[k+1]   <= q_s[k] | (ge ? (QW'(1) << SH) : '0);
				neg_s[k+1] <= neg_s[k];
				big_s[k+1] <= big_s[k];
			end
		end
	end

	logic [QW-1:0] lim;
	assign lim = QW'(1) << (OW-1);
	always_comb begin
		if (neg_s[QW]) begin
			sat = big_s[QW] || (q_s[QW] > lim);
			quo = sat ? OW'(lim) : OW'(-q_s[QW]);
		end else begin
			sat = big_s[QW] || (q_s[QW] > lim - QW'(1));
			quo = sat ? OW'(lim - QW'(1)) : OW'(q_s[QW]);
		end
	end
endmodule

[rtl/matrix3x3_inverse.sv]
// Top level of the 3x3 fixed-point matrix inverse pipeline.
//
// Usage: one input item is a whole 3x3 signed Q16.16 matrix on in_data, taken
// when in_valid and in_ready are both high. One result item per matrix leaves
// on out_data under out_valid/out_ready, in the order the items came in.
// Stage 1 registers the nine 2x2 cofactor products, stage 2 the cofactors,
// stage 3 the determinant partial products (each first-column element times
// the low and high halves of its cofactor), stage 4 the determinant, stage 5
// magnitudes and signs. A chain of DATA_WIDTH+1 divider stages then produces
// one quotient bit each, and a final output register holds the result item.
// Throughput is one item per cycle while the receiver does not stall.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, every stage holds, so nothing is lost or repeated, and
// in_ready drops. Ready stays high whenever the output register is free or
// being taken.
// Reset clears all valid bits; payload registers are not reset.
// A singular matrix (determinant exactly zero) gives zero elements,
// singular high and overflow low.
module matrix3x3_inverse import m3inv_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  mat_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output mat_out_t out_data
);
	localparam int DATA_WIDTH = DW;
	localparam int PW  = 2*DATA_WIDTH;       // product width
	localparam int CW  = PW + 1;             // cofactor width
	localparam int HW  = CW - DATA_WIDTH;    // high cofactor slice width
	localparam int DTW = DATA_WIDTH + CW + 2; // determinant width
	localparam int NW  = CW + 2*FRAC_BITS;   // scaled numerator width
	localparam int QW  = DATA_WIDTH + 1;
	localparam int NDIV = QW;
	localparam int NST  = 6 + NDIV;           // register stages including output reg

	// Advance the whole pipeline unless a result sits unaccepted at the end.
	logic adv;
	logic vld [NST+1];
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;
	assign vld[0]   = in_valid;

	for (genvar s = 0; s < NST; s++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld[s+1] <= 1'b0;
			else if (adv) vld[s+1] <= vld[s];
		end
	end

	logic signed [DATA_WIDTH-1:0] e [9];
	always_comb begin
		e[0] = in_data.m11[DATA_WIDTH-1:0]; e[1] = in_data.m12[DATA_WIDTH-1:0];
		e[2] = in_data.m13[DATA_WIDTH-1:0]; e[3] = in_data.m21[DATA_WIDTH-1:0];
		e[4] = in_data.m22[DATA_WIDTH-1:0]; e[5] = in_data.m23[DATA_WIDTH-1:0];
		e[6] = in_data.m31[DATA_WIDTH-1:0]; e[7] = in_data.m32[DATA_WIDTH-1:0];
		e[8] = in_data.m33[DATA_WIDTH-1:0];
	end

	// Cofactor operand indexes: adj[i] = e[a]*e[b] - e[c]*e[d].
	localparam int IA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int IB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int IC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int ID [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	// Stage 1: products.
	logic signed [PW-1:0] pa_s1 [9];
	logic signed [PW-1:0] pb_s1 [9];
	logic signed [DATA_WIDTH-1:0] e0_s1, e3_s1, e6_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 9; i++) begin
				pa_s1[i] <= e[IA[i]] * e[IB[i]];
				pb_s1[i] <= e[IC[i]] * e[ID[i]];
			end
			e0_s1 <= e[0]; e3_s1 <= e[3]; e6_s1 <= e[6];
		end
	end

	// Stage 2: cofactors.
	logic signed [CW-1:0] adj_s2 [9];
	logic signed [DATA_WIDTH-1:0] e0_s2, e3_s2, e6_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 9; i++)
				adj_s2[i] <= CW'(pa_s1[i]) - CW'(pb_s1[i]);
			e0_s2 <= e0_s1; e3_s2 <= e3_s1; e6_s2 <= e6_s1;
		end
	end

	// Stage 3: each determinant term is split into two word-sized products,
	// one with the unsigned low word of the cofactor and one with its signed
	// high slice.
	logic signed [DATA_WIDTH-1:0] col [3];
	logic signed [DATA_WIDTH:0]   alo [3];
	logic signed [HW-1:0]         ahi [3];
	always_comb begin
		col[0] = e0_s2; col[1] = e3_s2; col[2] = e6_s2;
		for (int j = 0; j < 3; j++) begin
			alo[j] = $signed({1'b0, adj_s2[j][DATA_WIDTH-1:0]});
			ahi[j] = $signed(adj_s2[j][CW-1:DATA_WIDTH]);
		end
	end

	logic signed [PW:0]   tlo_s3 [3];
	logic signed [PW:0]   thi_s3 [3];
	logic signed [CW-1:0] adj_s3 [9];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 3; j++) begin
				tlo_s3[j] <= (PW+1)'(col[j]) * (PW+1)'(alo[j]);
				thi_s3[j] <= (PW+1)'(col[j]) * (PW+1)'(ahi[j]);
			end
			adj_s3 <= adj_s2;
		end
	end

	// Stage 4: determinant sum along the first column.
	logic signed [DTW-1:0] det_s4;
	logic signed [CW-1:0]  adj_s4 [9];
	always_ff @(posedge clk) begin
		if (adv) begin
			det_s4 <= (DTW'(thi_s3[0]) <<< DATA_WIDTH) + DTW'(tlo_s3[0])
				+ (DTW'(thi_s3[1]) <<< DATA_WIDTH) + DTW'(tlo_s3[1])
				+ (DTW'(thi_s3[2]) <<< DATA_WIDTH) + DTW'(tlo_s3[2]);
			adj_s4 <= adj_s3;
		end
	end

	// Stage 5: magnitudes and signs for the dividers.
	logic [DTW-1:0] dmag;
	assign dmag = det_s4[DTW-1] ? DTW'(-det_s4) : det_s4;

	logic [NW-1:0]  num_s5 [9];
	logic           neg_s5 [9];
	logic [DTW-1:0] dmag_s5;
	logic           sing_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 9; i++) begin
				num_s5[i] <= NW'(adj_s4[i][CW-1] ? CW'(-adj_s4[i]) : adj_s4[i])
					<< (2*FRAC_BITS);
				neg_s5[i] <= adj_s4[i][CW-1] != det_s4[DTW-1];
			end
			dmag_s5 <= dmag;
			sing_s5 <= (det_s4 == '0);
		end
	end

	// Divider chain; singular flag delayed alongside.
	logic [DATA_WIDTH-1:0] q [9];
	logic                  sat [9];
	for (genvar i = 0; i < 9; i++) begin : g_div
		m3inv_div #(.NW(NW), .DWD(DTW), .QW(QW), .OW(DATA_WIDTH)) u_div (
			.clk (clk),
			.en  (adv),
			.num (num_s5[i]),
			.den (dmag_s5),
			.neg (neg_s5[i]),
			.quo (q[i]),
			.sat (sat[i])
		);
	end

	logic sing_d [NDIV+1];
	assign sing_d[0] = sing_s5;
	for (genvar k = 0; k < NDIV; k++) begin : g_sd
		always_ff @(posedge clk) begin
			if (adv) sing_d[k+1] <= sing_d[k];
		end
	end

	// Output register.
	logic [DW-1:0] r [9];
	logic          any_sat;
	always_comb begin
		any_sat = 1'b0;
		for (int i = 0; i < 9; i++) begin
			r[i] = sing_d[NDIV] ? '0 : DW'(signed'(q[i]));
			any_sat = any_sat | sat[i];
		end
	end

	assign out_valid = vld[NST];
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.inv11 <= r[0]; out_data.inv12 <= r[1]; out_data.inv13 <= r[2];
			out_data.inv21 <= r[3]; out_data.inv22 <= r[4]; out_data.inv23 <= r[5];
			out_data.inv31 <= r[6]; out_data.inv32 <= r[7]; out_data.inv33 <= r[8];
			out_data.singular <= sing_d[NDIV];
			out_data.overflow <= !sing_d[NDIV] && any_sat;
		end
	end
endmodule

[dv/tb.sv]
// Self-checking testbench for the 3x3 fixed-point matrix inverse pipeline.
`timescale 1ns / 100ps

import m3inv_pkg::*;

// Holds the inverses still owed by the block, in arrival order, and checks results.
class inverse_scoreboard;
	mat_out_t owed[$];
	int       mismatches;
	int       matched;
	int       singular_seen;
	int       overflow_seen;

	// Exact inverse through the adjugate, with 256-bit intermediates.
	static function mat_out_t invert(mat_in_t m);
		logic signed [255:0] e[9];
		logic signed [255:0] adj[9];
		logic signed [255:0] det;
		logic        [255:0] num;
		logic        [255:0] dmag;
		logic        [255:0] q;
		logic signed [DW-1:0] res[9];
		logic ovf;
		logic neg;
		mat_out_t r;
		e[0] = m.m11; e[1] = m.m12; e[2] = m.m13;
		e[3] = m.m21; e[4] = m.m22; e[5] = m.m23;
		e[6] = m.m31; e[7] = m.m32; e[8] = m.m33;
		adj[0] = e[4] * e[8] - e[5] * e[7];
		adj[1] = e[2] * e[7] - e[1] * e[8];
		adj[2] = e[1] * e[5] - e[2] * e[4];
		adj[3] = e[5] * e[6] - e[3] * e[8];
		adj[4] = e[0] * e[8] - e[2] * e[6];
		adj[5] = e[2] * e[3] - e[0] * e[5];
		adj[6] = e[3] * e[7] - e[4] * e[6];
		adj[7] = e[1] * e[6] - e[0] * e[7];
		adj[8] = e[0] * e[4] - e[1] * e[3];
		det = e[0] * adj[0] + e[3] * adj[1] + e[6] * adj[2];
		ovf = 1'b0;
		if (det == 0) begin
			r = '0;
			r.singular = 1'b1;
			return r;
		end
		dmag = det < 0 ? -det : det;
		for (int i = 0; i < 9; i++) begin
			neg = (adj[i] < 0) != (det < 0);
			num = adj[i] < 0 ? -adj[i] : adj[i];
			q = (num << (2 * FRAC_BITS_DEF)) / dmag;
			if (neg) begin
				if (q > (256'd1 << (DW - 1))) begin
					ovf = 1'b1;
					q = 256'd1 << (DW - 1);
				end
				res[i] = -q[DW-1:0];
			end else begin
				if (q > (256'd1 << (DW - 1)) - 1) begin
					ovf = 1'b1;
					q = (256'd1 << (DW - 1)) - 1;
				end
				res[i] = q[DW-1:0];
			end
		end
		r.inv11 = res[0]; r.inv12 = res[1]; r.inv13 = res[2];
		r.inv21 = res[3]; r.inv22 = res[4]; r.inv23 = res[5];
		r.inv31 = res[6]; r.inv32 = res[7]; r.inv33 = res[8];
		r.singular = 1'b0;
		r.overflow = ovf;
		return r;
	endfunction

	function void note_matrix(mat_in_t m);
		owed.push_back(invert(m));
	endfunction

	function void check_inverse(mat_out_t got);
		mat_out_t want;
		if (owed.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result with nothing outstanding: %h", got);
			return;
		end
		want = owed.pop_front();
		if (want.singular) singular_seen++;
		if (want.overflow) overflow_seen++;
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch #%0d: expected %h, got %h", mismatches, want, got);
		end else begin
			matched++;
		end
	endfunction
endclass

module tb;
	localparam int LATENCY = DW + 7;
	localparam longint LIMIT = 400000;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	mat_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	mat_out_t out_data;

	inverse_scoreboard sb;
	longint cycles = 0;
	// Set by the stimulus to order a long receiver hold-off.
	logic   hold_request;
	int     sent;

	matrix3x3_inverse u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		clk = 1'b0; #1;
		clk = 1'b1; #1;
	end

	// Cycle count and timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Results are sampled at the rising edge when the handshake completes.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_inverse(out_data);
	end

	// Receiver: stalls on a pseudo-random pattern, with a long hold-off
	// on request that lets the pipeline fill and push back on the sender.
	initial begin
		int phase;
		logic hold_done;
		out_ready = 1'b0;
		phase = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				out_ready <= 1'b0;
				for (int i = 0; i < 3 * LATENCY; i++) @(negedge clk);
				hold_done = 1'b1;
			end
			phase++;
			// Quiet windows with no stalls alternate with stall-heavy windows.
			if ((phase / 200) % 3 == 0)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	function automatic logic signed [DW-1:0] pick_element();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return $signed(32'($urandom_range(0, 'h3_0000))) - 32'sh1_8000;
			4: return $signed(32'($urandom_range(0, 'h300))) - 32'sh180;
			default: return $signed($urandom());
		endcase
	endfunction

	function automatic mat_in_t random_matrix();
		mat_in_t m;
		m.m11 = pick_element(); m.m12 = pick_element(); m.m13 = pick_element();
		m.m21 = pick_element(); m.m22 = pick_element(); m.m23 = pick_element();
		m.m31 = pick_element(); m.m32 = pick_element(); m.m33 = pick_element();
		// Some matrices get a repeated row so that the determinant is exactly zero.
		if ($urandom_range(0, 9) == 0) begin
			m.m31 = m.m11; m.m32 = m.m12; m.m33 = m.m13;
		end
		return m;
	endfunction

	// Offer one matrix and wait until the block takes it; valid stays high
	// across back-to-back items.
	task automatic send_matrix(mat_in_t m);
		in_valid <= 1'b1;
		in_data  <= m;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_matrix(m);
		sent++;
		@(negedge clk);
	endtask

	task automatic go_idle(int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.owed.size() != 0) @(negedge clk);
	endtask

	function automatic mat_in_t diag(logic signed [DW-1:0] a, logic signed [DW-1:0] b,
			logic signed [DW-1:0] c);
		mat_in_t m;
		m = '0;
		m.m11 = a; m.m22 = b; m.m33 = c;
		return m;
	endfunction

	initial begin
		mat_in_t m;
		sb = new();
		sent = 0;
		hold_request = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed matrices: identity, scaled diagonals, all-zero, extremes,
		// saturating quotients and a singular matrix with a repeated row.
		send_matrix(diag(32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
		send_matrix(diag(32'sh2_0000, -32'sh4_0000, 32'sh0_8000));
		send_matrix(diag(32'sh1, 32'sh1, 32'sh1));
		send_matrix(diag(-32'sh1, 32'sh1, 32'sh1));
		send_matrix(diag(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
		send_matrix(diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
		send_matrix(diag(32'sh8000_0000, 32'sh1, -32'sh1));
		send_matrix('0);
		m = '1;
		send_matrix(m);
		m = {9{32'sh8000_0000}};
		send_matrix(m);
		m = {9{32'sh7fff_ffff}};
		send_matrix(m);
		m = diag(32'sh1_0000, 32'sh1_0000, 32'sh1_0000);
		m.m12 = 32'sh7fff_ffff; m.m13 = 32'sh8000_0000; m.m23 = -32'sh3_0000;
		send_matrix(m);
		m.m21 = 32'sh8000_0000; m.m31 = 32'sh7fff_ffff; m.m32 = 32'sh5555_5555;
		send_matrix(m);
		m = '{m11: 32'sh1_0000, m12: 32'sh2_0000, m13: 32'sh3_0000,
			m21: 32'sh4_0000, m22: 32'sh5_0000, m23: 32'sh6_0000,
			m31: 32'sh7_0000, m32: 32'sh8_0000, m33: 32'sh9_0000};
		send_matrix(m);
		m.m33 = 32'sha_0000;
		send_matrix(m);
		m = {32'shaaaa_aaaa, 32'sh5555_5555, 32'sh0f0f_0f0f, 32'shf0f0_f0f0,
			32'sh1234_5678, 32'shedcb_a987, 32'sh0000_ffff, 32'shffff_0000, 32'sh3c3c_c3c3};
		send_matrix(m);
		// Sender pause until every expected inverse has come back.
		drain();

		// Random bursts; one long receiver hold-off part way through.
		while (sent < 420) begin
			for (int n = $urandom_range(1, 40); n > 0; n--) begin
				if (sent == 150) hold_request = 1'b1;
				send_matrix(random_matrix());
			end
			if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 12));
		end

		drain();
		repeat (2 * LATENCY) @(negedge clk);
		$display("Covered %0d matrices: %0d singular, %0d saturating, with stalls on both sides.",
			sent, sb.singular_seen, sb.overflow_seen);
		if (sb.mismatches == 0 && sb.owed.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

[sim.f]
rtl/m3inv_pkg.sv
rtl/m3inv_div.sv
rtl/matrix3x3_inverse.sv
dv/tb.sv
